### hdl/cc_cv_charge_controller_unit_macros.svh
// assertion macros for the cc/cv charge controller checker
// no dependencies; included by the checker file
`ifndef CC_CV_CHARGE_CONTROLLER_UNIT_MACROS_SVH
`define CC_CV_CHARGE_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define CCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("charge controller check failed");

// next-cycle implication, masked during reset
`define CCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("charge controller check failed");

// next-cycle implication that also holds across reset
`define CCC_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("charge controller check failed");

`endif

### hdl/ccc_pkg.sv
// shared types, constants and register codes for the cc/cv charge controller
// no dependencies; used by every module of the block
`default_nettype none

package ccc_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned ErrWidth  = 17;
  localparam int unsigned AccWidth  = 32;
  localparam int unsigned IdxWidth  = 3;

  // register indexes on the configuration port
  typedef enum logic [IdxWidth-1:0] {
    REG_CURRENT_TARGET    = 3'd0,
    REG_VOLTAGE_TARGET    = 3'd1,
    REG_CUTOFF_CURRENT    = 3'd2,
    REG_CURRENT_PROP_GAIN = 3'd3,
    REG_CURRENT_INT_GAIN  = 3'd4,
    REG_VOLTAGE_PROP_GAIN = 3'd5,
    REG_VOLTAGE_INT_GAIN  = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic [CfgWidth-1:0] RST_CURRENT_TARGET    = 16'd1000;
  localparam logic [CfgWidth-1:0] RST_VOLTAGE_TARGET    = 16'd4200;
  localparam logic [CfgWidth-1:0] RST_CUTOFF_CURRENT    = 16'd300;
  localparam logic [CfgWidth-1:0] RST_CURRENT_PROP_GAIN = 16'd13107;
  localparam logic [CfgWidth-1:0] RST_CURRENT_INT_GAIN  = 16'd1311;
  localparam logic [CfgWidth-1:0] RST_VOLTAGE_PROP_GAIN = 16'd19661;
  localparam logic [CfgWidth-1:0] RST_VOLTAGE_INT_GAIN  = 16'd1966;

  // charge mode as reported on the result word
  localparam logic [1:0] CODE_IDLE = 2'd0;
  localparam logic [1:0] CODE_CC   = 2'd1;
  localparam logic [1:0] CODE_CV   = 2'd2;

  // charger state, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_CC   = 3'b010,
    MODE_CV   = 3'b100
  } mode_t;

  typedef struct packed {
    logic [CfgWidth-1:0] current_target;
    logic [CfgWidth-1:0] voltage_target;
    logic [CfgWidth-1:0] cutoff_current;
    logic [CfgWidth-1:0] current_prop_gain;
    logic [CfgWidth-1:0] current_int_gain;
    logic [CfgWidth-1:0] voltage_prop_gain;
    logic [CfgWidth-1:0] voltage_int_gain;
  } cfg_t;

  typedef struct packed {
    logic [15:0] current_sample;
    logic [15:0] voltage_sample;
    logic        charge_enable;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         charge_mode;
    logic signed [31:0] current_drive;
    logic signed [31:0] voltage_drive;
    logic               charge_done;
  } out_word_t;

  // per-item control that travels down the pipeline
  typedef struct packed {
    logic       run;
    logic [1:0] mode_code;
    logic       done;
  } pipe_ctl_t;

  // operands of one pi loop after the integral update
  typedef struct packed {
    logic signed [ErrWidth-1:0] err;
    logic signed [AccWidth-1:0] accum;
  } loop_op_t;

endpackage

`default_nettype wire

### hdl/ccc_ctrl.sv
// mode sequencer and integral update for both pi loops (first work stage)
// depends on ccc_pkg
`default_nettype none

module ccc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire ccc_pkg::in_word_t  word,
  input  wire ccc_pkg::cfg_t      cfg,
  output ccc_pkg::pipe_ctl_t      ctl,
  output ccc_pkg::loop_op_t       cur_op,
  output ccc_pkg::loop_op_t       volt_op
);

  ccc_pkg::mode_t mode, mode_next;
  logic signed [ccc_pkg::AccWidth-1:0] current_accum, voltage_accum;
  logic signed [ccc_pkg::AccWidth-1:0] current_accum_next, voltage_accum_next;
  logic signed [ccc_pkg::ErrWidth-1:0] cur_err, volt_err;
  logic run, done;
  logic [1:0] code_next;

  // saturating add of an error into a 32-bit integral
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] acc,
                                                 input logic signed [16:0] e);
    logic signed [32:0] s;
    s = {acc[31], acc} + {{16{e[16]}}, e};
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // errors and next integrals
  assign cur_err  = $signed({1'b0, cfg.current_target}) - $signed({1'b0, word.current_sample});
  assign volt_err = $signed({1'b0, cfg.voltage_target}) - $signed({1'b0, word.voltage_sample});
  assign run      = (mode == ccc_pkg::MODE_CC) || (mode == ccc_pkg::MODE_CV);
  assign current_accum_next = run ? sat_add(current_accum, cur_err) : current_accum;
  assign voltage_accum_next = run ? sat_add(voltage_accum, volt_err) : voltage_accum;

  // mode transitions, loops run before the test
  always_comb begin
    mode_next = ccc_pkg::MODE_IDLE;
    done      = 1'b0;
    case (mode)
      ccc_pkg::MODE_CC: begin
        mode_next = (word.voltage_sample >= cfg.voltage_target) ? ccc_pkg::MODE_CV
                                                                 : ccc_pkg::MODE_CC;
      end
      ccc_pkg::MODE_CV: begin
        if (word.current_sample <= cfg.cutoff_current) begin
          mode_next = ccc_pkg::MODE_IDLE;
          done      = 1'b1;
        end else begin
          mode_next = ccc_pkg::MODE_CV;
        end
      end
      default: begin
        mode_next = word.charge_enable ? ccc_pkg::MODE_CC : ccc_pkg::MODE_IDLE;
      end
    endcase
  end

  // reported mode code
  always_comb begin
    case (mode_next)
      ccc_pkg::MODE_CC: code_next = ccc_pkg::CODE_CC;
      ccc_pkg::MODE_CV: code_next = ccc_pkg::CODE_CV;
      default:          code_next = ccc_pkg::CODE_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= ccc_pkg::MODE_IDLE;
      current_accum <= '0;
      voltage_accum <= '0;
    end else if (adv) begin
      mode          <= mode_next;
      current_accum <= current_accum_next;
      voltage_accum <= voltage_accum_next;
    end
  end

  // stage output registers
  always_ff @(posedge clk) begin
    if (adv) begin
      ctl.run       <= run;
      ctl.mode_code <= code_next;
      ctl.done      <= done;
      cur_op.err    <= cur_err;
      cur_op.accum  <= current_accum_next;
      volt_op.err   <= volt_err;
      volt_op.accum <= voltage_accum_next;
    end
  end

endmodule

`default_nettype wire

### hdl/ccc_pi_loop.sv
// pi output path: registered products, then sum, floor shift and saturation
// depends on ccc_pkg
`default_nettype none

module ccc_pi_loop (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv_mul,
  input  wire logic                        adv_sum,
  input  wire logic                        run,
  input  wire ccc_pkg::loop_op_t           op,
  input  wire logic [ccc_pkg::CfgWidth-1:0] kp,
  input  wire logic [ccc_pkg::CfgWidth-1:0] ki,
  output logic signed [31:0]               drive
);

  logic signed [16:0] kp_s, ki_s;
  logic signed [33:0] prop_prod;
  logic signed [48:0] int_prod;
  logic signed [49:0] sum;
  logic signed [33:0] quot;
  logic signed [31:0] drive_next;

  assign kp_s = $signed({1'b0, kp});
  assign ki_s = $signed({1'b0, ki});

  // products, one multiplier each
  always_ff @(posedge clk) begin
    if (adv_mul) begin
      prop_prod <= kp_s * op.err;
      int_prod  <= ki_s * op.accum;
    end
  end

  // sum, floor divide by 2^16, saturate
  assign sum  = {{16{prop_prod[33]}}, prop_prod} + {int_prod[48], int_prod};
  assign quot = sum[49:16];

  always_comb begin
    if (quot[33:31] == 3'b000 || quot[33:31] == 3'b111) begin
      drive_next = quot[31:0];
    end else if (quot[33]) begin
      drive_next = 32'sh8000_0000;
    end else begin
      drive_next = 32'sh7fff_ffff;
    end
  end

  // held drive, updated only by items taken in a charge mode
  always_ff @(posedge clk) begin
    if (rst) begin
      drive <= '0;
    end else if (adv_sum && run) begin
      drive <= drive_next;
    end
  end

endmodule

`default_nettype wire

### hdl/cc_cv_charge_controller_unit.sv
// cc/cv charge controller: register file, pipeline control and result word
// depends on ccc_pkg, ccc_ctrl, ccc_pi_loop
//
//   channel  signals                          word
//   in       in_valid / in_ready / in_data    current and voltage samples, enable
//   out      out_valid / out_ready / out_data mode, two drives, done flag
//   cfg      cfg_valid / cfg_ready            cfg_index, cfg_data (always ready)
//
// one word per cycle sustained unless the output stalls; the result is registered at the last stage
// stages: input register, mode and integral update, products, sum and saturate
// the integrals and mode change at the integral stage, so each word sees the
// state left by the one before it with no bubble
// synchronous reset clears mode, integrals, held drives and valid flags, and loads the config reset values
// a stall on the output backs up combinationally through every full stage in the same cycle
`default_nettype none

module cc_cv_charge_controller_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire ccc_pkg::in_word_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output ccc_pkg::out_word_t                out_data,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [ccc_pkg::IdxWidth-1:0] cfg_index,
  input  wire logic [ccc_pkg::CfgWidth-1:0] cfg_data
);

  ccc_pkg::cfg_t      cfg;
  ccc_pkg::in_word_t  in_reg;
  ccc_pkg::pipe_ctl_t ctl1, ctl2, ctl3;
  ccc_pkg::loop_op_t  cur_op, volt_op;
  logic v0, v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic adv0, adv1, adv2, adv3;
  logic signed [31:0] cur_drive, volt_drive;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_target    <= ccc_pkg::RST_CURRENT_TARGET;
      cfg.voltage_target    <= ccc_pkg::RST_VOLTAGE_TARGET;
      cfg.cutoff_current    <= ccc_pkg::RST_CUTOFF_CURRENT;
      cfg.current_prop_gain <= ccc_pkg::RST_CURRENT_PROP_GAIN;
      cfg.current_int_gain  <= ccc_pkg::RST_CURRENT_INT_GAIN;
      cfg.voltage_prop_gain <= ccc_pkg::RST_VOLTAGE_PROP_GAIN;
      cfg.voltage_int_gain  <= ccc_pkg::RST_VOLTAGE_INT_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ccc_pkg::REG_CURRENT_TARGET:    cfg.current_target    <= cfg_data;
        ccc_pkg::REG_VOLTAGE_TARGET:    cfg.voltage_target    <= cfg_data;
        ccc_pkg::REG_CUTOFF_CURRENT:    cfg.cutoff_current    <= cfg_data;
        ccc_pkg::REG_CURRENT_PROP_GAIN: cfg.current_prop_gain <= cfg_data;
        ccc_pkg::REG_CURRENT_INT_GAIN:  cfg.current_int_gain  <= cfg_data;
        ccc_pkg::REG_VOLTAGE_PROP_GAIN: cfg.voltage_prop_gain <= cfg_data;
        ccc_pkg::REG_VOLTAGE_INT_GAIN:  cfg.voltage_int_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall chain, each stage takes a word when it is empty or being drained
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = !v0 || rdy1;
  assign adv0     = in_valid && in_ready;
  assign adv1     = v0 && rdy1;
  assign adv2     = v1 && rdy2;
  assign adv3     = v2 && rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= adv0 || (v0 && !rdy1);
      v1 <= adv1 || (v1 && !rdy2);
      v2 <= adv2 || (v2 && !rdy3);
      v3 <= adv3 || (v3 && !out_ready);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (adv0) begin
      in_reg <= in_data;
    end
  end

  // mode and integral stage
  ccc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv1),
    .word    (in_reg),
    .cfg     (cfg),
    .ctl     (ctl1),
    .cur_op  (cur_op),
    .volt_op (volt_op)
  );

  // control alongside the two arithmetic stages
  always_ff @(posedge clk) begin
    if (adv2) begin
      ctl2 <= ctl1;
    end
    if (adv3) begin
      ctl3 <= ctl2;
    end
  end

  // current loop
  ccc_pi_loop u_cur_loop (
    .clk     (clk),
    .rst     (rst),
    .adv_mul (adv2),
    .adv_sum (adv3),
    .run     (ctl2.run),
    .op      (cur_op),
    .kp      (cfg.current_prop_gain),
    .ki      (cfg.current_int_gain),
    .drive   (cur_drive)
  );

  // voltage loop
  ccc_pi_loop u_volt_loop (
    .clk     (clk),
    .rst     (rst),
    .adv_mul (adv2),
    .adv_sum (adv3),
    .run     (ctl2.run),
    .op      (volt_op),
    .kp      (cfg.voltage_prop_gain),
    .ki      (cfg.voltage_int_gain),
    .drive   (volt_drive)
  );

  // result word
  assign out_valid              = v3;
  assign out_data.charge_mode   = ctl3.mode_code;
  assign out_data.current_drive = cur_drive;
  assign out_data.voltage_drive = volt_drive;
  assign out_data.charge_done   = ctl3.done;

endmodule

`default_nettype wire

### hdl/ccc_checker.sv
// port-level checks for the cc/cv charge controller, bound to the top level
// depends on ccc_pkg and cc_cv_charge_controller_unit_macros.svh
`default_nettype none
`include "cc_cv_charge_controller_unit_macros.svh"

module ccc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire ccc_pkg::out_word_t out_data,
  input wire logic               cfg_ready
);

  // a stalled result word holds
  `CCC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // charging ends only by going back to idle
  `CCC_ASSERT_IMP(a_done_idle, out_valid && out_data.charge_done,
                  out_data.charge_mode == ccc_pkg::CODE_IDLE)

  // the unused mode code never shows
  `CCC_ASSERT_IMP(a_mode_code, out_valid, out_data.charge_mode <= ccc_pkg::CODE_CV)

  // nothing comes out right after reset, and config is always taken
  `CCC_ASSERT_RST(a_rst_empty, rst, !out_valid && cfg_ready)

endmodule

bind cc_cv_charge_controller_unit ccc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
